### hdl/ips_patch_stream_decoder_macros.svh
// Assertion macros shared by the patch stream decoder RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef IPS_PATCH_STREAM_DECODER_MACROS_SVH
`define IPS_PATCH_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IPSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ipsd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define IPSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipsd assertion failed");

`endif

### hdl/ipsd_pkg.sv
// Types and constants for the patch stream decoder.
// Used by ips_patch_stream_decoder; depends on nothing.
`default_nettype none

package ipsd_pkg;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_OFFSET = 3'd1,
        PH_SIZE   = 3'd2,
        PH_DATA   = 3'd3,
        PH_RUNLEN = 3'd4,
        PH_RUNVAL = 3'd5,
        PH_DONE   = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        KIND_LITERAL    = 2'd0,
        KIND_FILL       = 2'd1,
        KIND_END        = 2'd2,
        KIND_BAD_HEADER = 2'd3
    } kind_t;

    localparam logic [2:0]  HEADER_LEN  = 3'd5;
    localparam logic [2:0]  OFFSET_LEN  = 3'd3;
    localparam logic [2:0]  SIZE_LEN    = 3'd2;
    localparam logic [23:0] END_MARK    = 24'h454F46;

    // Expected header text "PATCH", one character per position.
    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] val;
        unique case (idx)
            3'd0:    val = 8'h50;
            3'd1:    val = 8'h41;
            3'd2:    val = 8'h54;
            3'd3:    val = 8'h43;
            3'd4:    val = 8'h48;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

### hdl/ips_patch_stream_decoder.sv
// Patch stream decoder: one patch byte per cycle in, write/fill/end commands out.
// A result is registered and appears on m_axis in the cycle after the byte that causes it.
// Throughput: one byte per cycle; s_axis_tready drops only while a result is held
// in the output register and m_axis_tready is low.
// Reset (rst_n low, asynchronous) returns the parser to header checking and clears
// the tallies; after an end marker or a bad header, bytes are taken and dropped.
`default_nettype none

`include "ips_patch_stream_decoder_macros.svh"

module ips_patch_stream_decoder #(
    parameter int TALLY_WIDTH = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] patch_byte
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [23:0] target_address, [31:24] fill_byte, [47:32] fill_length,
    // [79:48] records_total, [111:80] bytes_total
    output logic [111:0]      m_axis_tdata,
    output logic [1:0]        m_axis_tuser    // [1:0] kind
);

    localparam int EXT_W = (TALLY_WIDTH > 32) ? TALLY_WIDTH : 33;
    localparam logic [TALLY_WIDTH-1:0] TALLY_MAX = '1;

    ipsd_pkg::phase_t         phase_reg, phase_next;
    logic [2:0]               field_index_reg, field_index_next;
    logic                     header_ok_reg, header_ok_next;
    logic [23:0]              offset_shift_reg, offset_shift_next;
    logic [15:0]              length_shift_reg, length_shift_next;
    logic [23:0]              write_pointer_reg, write_pointer_next;
    logic [15:0]              bytes_left_reg, bytes_left_next;
    logic [TALLY_WIDTH-1:0]   record_tally_reg, record_tally_next;
    logic [TALLY_WIDTH-1:0]   byte_tally_reg, byte_tally_next;

    logic                     out_valid_reg, out_valid_next;
    logic [1:0]               out_kind_reg, out_kind_next;
    logic [111:0]             out_data_reg, out_data_next;

    logic                     accept;
    logic [7:0]               b;
    logic [23:0]              offset_in;
    logic [15:0]              length_in;
    logic                     emit;
    ipsd_pkg::kind_t          emit_kind;
    logic [23:0]              emit_addr;
    logic [7:0]               emit_fill;
    logic [15:0]              emit_len;
    logic [TALLY_WIDTH:0]     rec_inc, byte_inc, byte_add;
    logic [TALLY_WIDTH-1:0]   rec_sat, byte_sat1, byte_satn;
    logic [EXT_W-1:0]         rec_ext, byte_ext;
    logic [31:0]              rec_out, byte_out;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata;
    assign offset_in     = {offset_shift_reg[15:0], b};
    assign length_in     = {length_shift_reg[7:0], b};

    // Saturating tally updates: the carry out of the extended sum marks overflow.
    assign rec_inc   = {1'b0, record_tally_reg} + (TALLY_WIDTH+1)'(1);
    assign byte_inc  = {1'b0, byte_tally_reg} + (TALLY_WIDTH+1)'(1);
    assign byte_add  = {1'b0, byte_tally_reg} + (TALLY_WIDTH+1)'(length_shift_reg);
    assign rec_sat   = rec_inc[TALLY_WIDTH]  ? TALLY_MAX : rec_inc[TALLY_WIDTH-1:0];
    assign byte_sat1 = byte_inc[TALLY_WIDTH] ? TALLY_MAX : byte_inc[TALLY_WIDTH-1:0];
    assign byte_satn = byte_add[TALLY_WIDTH] ? TALLY_MAX : byte_add[TALLY_WIDTH-1:0];

    // Totals reported on the end marker are clipped to 32 bits.
    assign rec_ext  = EXT_W'(record_tally_reg);
    assign byte_ext = EXT_W'(byte_tally_reg);
    assign rec_out  = (|rec_ext[EXT_W-1:32])  ? 32'hFFFF_FFFF : rec_ext[31:0];
    assign byte_out = (|byte_ext[EXT_W-1:32]) ? 32'hFFFF_FFFF : byte_ext[31:0];

    always_comb
    begin
        phase_next         = phase_reg;
        field_index_next   = field_index_reg;
        header_ok_next     = header_ok_reg;
        offset_shift_next  = offset_shift_reg;
        length_shift_next  = length_shift_reg;
        write_pointer_next = write_pointer_reg;
        bytes_left_next    = bytes_left_reg;
        record_tally_next  = record_tally_reg;
        byte_tally_next    = byte_tally_reg;
        emit               = 1'b0;
        emit_kind          = ipsd_pkg::KIND_LITERAL;
        emit_addr          = '0;
        emit_fill          = '0;
        emit_len           = '0;

        if (accept)
        begin
            unique case (phase_reg)
                ipsd_pkg::PH_HEADER:
                begin
                    if (b != ipsd_pkg::magic_byte(field_index_reg))
                        header_ok_next = 1'b0;
                    field_index_next = field_index_reg + 3'd1;
                    if (field_index_reg == ipsd_pkg::HEADER_LEN - 3'd1)
                    begin
                        field_index_next = '0;
                        if (header_ok_reg && b == ipsd_pkg::magic_byte(field_index_reg))
                            phase_next = ipsd_pkg::PH_OFFSET;
                        else
                        begin
                            phase_next = ipsd_pkg::PH_DONE;
                            emit       = 1'b1;
                            emit_kind  = ipsd_pkg::KIND_BAD_HEADER;
                        end
                    end
                end
                ipsd_pkg::PH_OFFSET:
                begin
                    offset_shift_next = offset_in;
                    field_index_next  = field_index_reg + 3'd1;
                    if (field_index_reg == ipsd_pkg::OFFSET_LEN - 3'd1)
                    begin
                        field_index_next = '0;
                        if (offset_in == ipsd_pkg::END_MARK)
                        begin
                            phase_next = ipsd_pkg::PH_DONE;
                            emit       = 1'b1;
                            emit_kind  = ipsd_pkg::KIND_END;
                        end
                        else
                        begin
                            write_pointer_next = offset_in;
                            phase_next         = ipsd_pkg::PH_SIZE;
                        end
                    end
                end
                ipsd_pkg::PH_SIZE:
                begin
                    length_shift_next = length_in;
                    field_index_next  = field_index_reg + 3'd1;
                    if (field_index_reg == ipsd_pkg::SIZE_LEN - 3'd1)
                    begin
                        field_index_next = '0;
                        if (length_in != '0)
                        begin
                            bytes_left_next = length_in;
                            phase_next      = ipsd_pkg::PH_DATA;
                        end
                        else
                            phase_next = ipsd_pkg::PH_RUNLEN;
                    end
                end
                ipsd_pkg::PH_DATA:
                begin
                    write_pointer_next = write_pointer_reg + 24'd1;
                    byte_tally_next    = byte_sat1;
                    bytes_left_next    = bytes_left_reg - 16'd1;
                    if (bytes_left_reg == 16'd1)
                    begin
                        record_tally_next = rec_sat;
                        phase_next        = ipsd_pkg::PH_OFFSET;
                    end
                    emit      = 1'b1;
                    emit_kind = ipsd_pkg::KIND_LITERAL;
                    emit_addr = write_pointer_reg;
                    emit_fill = b;
                    emit_len  = 16'd1;
                end
                ipsd_pkg::PH_RUNLEN:
                begin
                    length_shift_next = length_in;
                    field_index_next  = field_index_reg + 3'd1;
                    if (field_index_reg == ipsd_pkg::SIZE_LEN - 3'd1)
                    begin
                        field_index_next = '0;
                        phase_next       = ipsd_pkg::PH_RUNVAL;
                    end
                end
                ipsd_pkg::PH_RUNVAL:
                begin
                    byte_tally_next   = byte_satn;
                    record_tally_next = rec_sat;
                    phase_next        = ipsd_pkg::PH_OFFSET;
                    // A zero-length run still counts as a record but emits nothing.
                    if (length_shift_reg != '0)
                    begin
                        emit      = 1'b1;
                        emit_kind = ipsd_pkg::KIND_FILL;
                        emit_addr = write_pointer_reg;
                        emit_fill = b;
                        emit_len  = length_shift_reg;
                    end
                end
                default:
                begin
                    phase_next = ipsd_pkg::PH_DONE;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_data_next  = out_data_reg;
        if (accept && emit)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = emit_kind;
            if (emit_kind == ipsd_pkg::KIND_END)
                out_data_next = {byte_out, rec_out, 48'd0};
            else
                out_data_next = {64'd0, emit_len, emit_fill, emit_addr};
        end
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= ipsd_pkg::PH_HEADER;
            field_index_reg   <= '0;
            header_ok_reg     <= 1'b1;
            offset_shift_reg  <= '0;
            length_shift_reg  <= '0;
            write_pointer_reg <= '0;
            bytes_left_reg    <= '0;
            record_tally_reg  <= '0;
            byte_tally_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            field_index_reg   <= field_index_next;
            header_ok_reg     <= header_ok_next;
            offset_shift_reg  <= offset_shift_next;
            length_shift_reg  <= length_shift_next;
            write_pointer_reg <= write_pointer_next;
            bytes_left_reg    <= bytes_left_next;
            record_tally_reg  <= record_tally_next;
            byte_tally_reg    <= byte_tally_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = out_data_reg;

    // Once finished or failed, the parser never leaves the done phase.
    `IPSD_ASSERT_NEXT(a_done_sticky, clk, rst_n,
        phase_reg == ipsd_pkg::PH_DONE, phase_reg == ipsd_pkg::PH_DONE)
    // Every accepted literal byte yields a literal write transaction.
    `IPSD_ASSERT_NEXT(a_literal_emits, clk, rst_n,
        accept && phase_reg == ipsd_pkg::PH_DATA,
        m_axis_tvalid && m_axis_tuser == ipsd_pkg::KIND_LITERAL)
    // The data phase always has at least one byte still to come.
    `IPSD_ASSERT_NOW(a_data_nonempty, clk, rst_n,
        phase_reg == ipsd_pkg::PH_DATA, bytes_left_reg != 16'd0)
    // The field counter never runs past the longest field, the header.
    `IPSD_ASSERT_NOW(a_index_bound, clk, rst_n,
        1'b1, field_index_reg < ipsd_pkg::HEADER_LEN)

endmodule

`default_nettype wire
